[src/psml_pkg.sv]
// Package for the sample mixer and limiter: constants, commands and types.
// No dependencies.
package psml_pkg;
	localparam int NumVoices  = 10;
	localparam int TableDepth = 4096;
	localparam int VoiceW     = $clog2(NumVoices);
	localparam int AddrW      = $clog2(TableDepth);
	localparam int PosW       = AddrW + 1;
	localparam int MemDepth   = 3 * TableDepth;
	localparam int MemAddrW   = $clog2(MemDepth);
	localparam logic [15:0] Unity   = 16'd32768;
	localparam logic [14:0] Ceiling = 15'd31130;
	localparam int RelShift = 11;

	typedef enum logic [1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_TRIGGER = 2'd1,
		CMD_LOAD    = 2'd2,
		CMD_STOP    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_MASTER = 3'd0,
		REG_DUCK   = 3'd1,
		REG_MUTED  = 3'd2,
		REG_LEN_S  = 3'd3,
		REG_LEN_N  = 3'd4,
		REG_LEN_SUB = 3'd5
	} reg_t;

	// voice record held in the voice RAM
	typedef struct packed {
		logic            started;
		logic [1:0]      tbl;
		logic [PosW-1:0] pos;
	} voice_t;

	localparam int VoiceRecW = $bits(voice_t);
endpackage

[src/polyphonic_sample_mixer_limiter.sv]
// Top level of the ten-voice sample mixer with peak limiter.
// Depends on psml_pkg, psml_ram and psml_div.
//
// Requests arrive one at a time on the s_axis side, with the command in tuser, and
// each returns exactly one result on m_axis. Load, trigger and stop go from
// acceptance straight to the result state. A sample walks the voice RAM one voice per
// cycle with a table memory read behind it, then the gain multiply, the amplify
// step, a 30-step serial divide only when the peak exceeds the ceiling, the
// limiter update and the output multiply. Table memory contents are undefined
// until loaded. A result register holds the answer so the next request is taken
// while it waits; that request's result then waits until the previous one has left.
module polyphonic_sample_mixer_limiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] cmd
	input  logic [1:0]  s_axis_tuser,
	// [1:0] tick_kind, [13:2] table_addr, [29:14] table_word
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] sample_out, [19:16] voice_used, [20] voice_stolen, [24:21] active_voices
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import psml_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_DRAIN, ST_GAIN, ST_AMP, ST_DIV, ST_LIM, ST_OUT, ST_RES
	} state_t;

	state_t state_q;
	logic [15:0] master_q, duck_q;
	logic        muted_q;
	logic [12:0] len_q [3];

	logic [NumVoices-1:0] active_q;
	logic [VoiceW-1:0]    steal_q;
	logic [15:0]          lim_q;

	logic [1:0]  cmd_q, tt_q;
	logic [AddrW-1:0] addr_q;
	logic [15:0] word_q;

	logic [VoiceW-1:0] vidx_q;
	logic              rd_valid_s1, rd_valid_s2;
	logic [VoiceW-1:0] rd_idx_s1;
	logic signed [19:0] acc_q;
	logic [15:0] gin_q;
	logic signed [19:0] amp_q;
	logic [19:0] mag_q;
	logic [15:0] desired_q;
	logic signed [15:0] out_q;
	logic [3:0]  used_q;
	logic        stolen_q;

	// voice RAM
	logic              vwe;
	logic [VoiceW-1:0] vwaddr, vraddr;
	voice_t            vwdata, vrdata;
	psml_ram #(.Width(VoiceRecW), .Depth(NumVoices)) u_vram (
		.clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
		.raddr(vraddr), .rdata(vrdata)
	);

	// sample memory
	logic                mwe;
	logic [MemAddrW-1:0] mwaddr, mraddr;
	logic [15:0]         mrdata;
	psml_ram #(.Width(16), .Depth(MemDepth)) u_smem (
		.clk(clk), .we(mwe), .waddr(mwaddr), .wdata(word_q),
		.raddr(mraddr), .rdata(mrdata)
	);

	logic        div_start, div_done;
	logic [15:0] div_q;
	psml_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .mag(mag_q),
		.done(div_done), .quot(div_q)
	);

	// voice lookup in stage 1
	voice_t      v_cur;
	logic [12:0] v_len;
	logic [12:0] v_lenraw;
	logic [PosW-1:0] v_pos;
	logic        v_play;
	always_comb begin
		v_cur = vrdata;
		v_pos = v_cur.started ? v_cur.pos : '0;
		unique case (v_cur.tbl)
			2'd1: v_lenraw = len_q[0];
			2'd2: v_lenraw = len_q[1];
			2'd3: v_lenraw = len_q[2];
			default: v_lenraw = '0;
		endcase
		v_len  = (v_lenraw > 13'(TableDepth)) ? 13'(TableDepth) : v_lenraw;
		v_play = 13'(v_pos) < v_len;
	end

	always_comb begin
		vwe = 1'b0; vwaddr = rd_idx_s1; vwdata = v_cur;
		vraddr = vidx_q;
		mwe = 1'b0;
		mwaddr = MemAddrW'((32'(tt_q) - 32'd1) * TableDepth + 32'(addr_q));
		mraddr = MemAddrW'((32'(v_cur.tbl) - 32'd1) * TableDepth + 32'(v_pos));
		if ((state_q == ST_SCAN || state_q == ST_DRAIN) && rd_valid_s1
			&& active_q[rd_idx_s1]) begin
			vwe = 1'b1;
			vwdata.started = v_play;
			vwdata.pos     = v_play ? v_pos + PosW'(1) : '0;
		end
		if (state_q == ST_RES && cmd_q == CMD_TRIGGER) begin
			vwe = 1'b1; vwaddr = used_q[VoiceW-1:0];
			vwdata.started = 1'b0; vwdata.tbl = tt_q; vwdata.pos = '0;
		end
		if (state_q == ST_RES && cmd_q == CMD_LOAD && tt_q != 2'd0) begin
			mwe = 1'b1;
		end
	end

	logic [VoiceW-1:0] free_idx;
	logic              free_any;
	always_comb begin
		free_idx = '0; free_any = 1'b0;
		for (int i = NumVoices - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = VoiceW'(i); free_any = 1'b1;
			end
		end
	end

	logic [15:0] mv, dv;
	logic [31:0] mvdv;
	logic signed [36:0] ampfull, outfull;
	logic signed [19:0] ampf;
	logic [19:0] ampf_mag;
	logic signed [20:0] accsum;
	logic [15:0] relgain;
	assign mv = (master_q > Unity) ? Unity : master_q;
	assign dv = (duck_q > Unity) ? Unity : duck_q;
	assign mvdv = mv * dv;
	assign ampfull = acc_q * $signed({1'b0, gin_q});
	assign outfull = amp_q * $signed({1'b0, lim_q});
	assign accsum = 21'(acc_q) + 21'($signed(mrdata));
	assign relgain = lim_q + 16'((17'(Unity - lim_q) + 17'((1 << RelShift) - 1)) >> RelShift);
	always_comb begin
		if ($signed(ampfull[36:15]) > 22'sd524287) ampf = 20'sd524287;
		else if ($signed(ampfull[36:15]) < -22'sd524288) ampf = -20'sd524288;
		else ampf = ampfull[34:15];
	end
	assign ampf_mag = ampf[19] ? 20'(-ampf) : 20'(ampf);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_AMP) && (ampf_mag > 20'(Ceiling));

	logic [3:0] cnt_next;
	always_comb begin
		logic [NumVoices-1:0] a;
		a = active_q;
		if (cmd_q == CMD_TRIGGER) a[used_q[VoiceW-1:0]] = 1'b1;
		if (cmd_q == CMD_STOP) a = '0;
		cnt_next = 4'($countones(a));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			master_q <= Unity; duck_q <= Unity; muted_q <= 1'b0;
			len_q[0] <= '0; len_q[1] <= '0; len_q[2] <= '0;
			active_q <= '0; steal_q <= '0; lim_q <= Unity;
			m_axis_tvalid <= 1'b0; m_axis_tdata <= '0;
			rd_valid_s1 <= 1'b0; rd_valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MASTER:  master_q <= cfg_data;
					REG_DUCK:    duck_q <= cfg_data;
					REG_MUTED:   muted_q <= cfg_data[0];
					REG_LEN_S:   len_q[0] <= cfg_data[12:0];
					REG_LEN_N:   len_q[1] <= cfg_data[12:0];
					REG_LEN_SUB: len_q[2] <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					cmd_q  <= s_axis_tuser;
					tt_q   <= s_axis_tdata[1:0];
					addr_q <= s_axis_tdata[2 +: AddrW];
					word_q <= s_axis_tdata[29:14];
					out_q <= '0;
					used_q <= (s_axis_tuser == CMD_TRIGGER) ?
						4'(free_any ? free_idx : steal_q) : '0;
					stolen_q <= (s_axis_tuser == CMD_TRIGGER) && !free_any;
					acc_q <= '0; vidx_q <= '0;
					rd_valid_s1 <= 1'b0; rd_valid_s2 <= 1'b0;
					state_q <= (s_axis_tuser == CMD_SAMPLE) ? ST_SCAN : ST_RES;
				end
				ST_SCAN: begin
					rd_valid_s1 <= 1'b1;
					rd_idx_s1 <= vidx_q;
					if (vidx_q == VoiceW'(NumVoices - 1)) state_q <= ST_DRAIN;
					else vidx_q <= vidx_q + VoiceW'(1);
					rd_valid_s2 <= rd_valid_s1 && active_q[rd_idx_s1] && v_play;
					if (rd_valid_s1 && active_q[rd_idx_s1] && !v_play)
						active_q[rd_idx_s1] <= 1'b0;
					if (rd_valid_s2) begin
						if (accsum > 21'sd524287) acc_q <= 20'sd524287;
						else if (accsum < -21'sd524288) acc_q <= -20'sd524288;
						else acc_q <= accsum[19:0];
					end
				end
				ST_DRAIN: begin
					// last voice in stage 1, then its sample in stage 2
					rd_valid_s1 <= 1'b0;
					rd_valid_s2 <= rd_valid_s1 && active_q[rd_idx_s1] && v_play;
					if (rd_valid_s1 && active_q[rd_idx_s1] && !v_play)
						active_q[rd_idx_s1] <= 1'b0;
					if (rd_valid_s2) begin
						if (accsum > 21'sd524287) acc_q <= 20'sd524287;
						else if (accsum < -21'sd524288) acc_q <= -20'sd524288;
						else acc_q <= accsum[19:0];
					end
					if (!rd_valid_s1 && !rd_valid_s2) state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					gin_q <= muted_q ? 16'd0 : mvdv[30:15];
					state_q <= ST_AMP;
				end
				ST_AMP: begin
					amp_q <= ampf;
					mag_q <= ampf_mag;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (mag_q <= 20'(Ceiling)) begin
						desired_q <= Unity; state_q <= ST_LIM;
					end else if (div_done) begin
						desired_q <= div_q; state_q <= ST_LIM;
					end
				end
				ST_LIM: begin
					lim_q <= (desired_q < lim_q) ? desired_q :
						((relgain > Unity) ? Unity : relgain);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if ($signed(outfull[36:15]) > 22'sd32767) out_q <= 16'sd32767;
					else if ($signed(outfull[36:15]) < -22'sd32768) out_q <= -16'sd32768;
					else out_q <= outfull[30:15];
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (!m_axis_tvalid) begin
						unique case (cmd_q)
							CMD_TRIGGER: begin
								active_q[free_any ? free_idx : steal_q] <= 1'b1;
								if (!free_any) steal_q <= (steal_q == VoiceW'(NumVoices - 1)) ?
									'0 : steal_q + VoiceW'(1);
							end
							CMD_STOP: begin
								active_q <= '0; steal_q <= '0;
							end
							default: ;
						endcase
						m_axis_tdata <= {7'd0, cnt_next, stolen_q, used_q, out_q};
						m_axis_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[src/psml_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module psml_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/psml_div.sv]
// Restoring divider, one quotient bit per cycle: (Ceiling << 15) / mag.
// Depends on psml_pkg.
module psml_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [19:0] mag,
	output logic        done,
	output logic [15:0] quot
);
	import psml_pkg::*;

	logic [29:0] num_q;
	logic [20:0] rem_q;
	logic [29:0] qt_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [20:0] trial;

	assign trial = {rem_q[19:0], num_q[29]};
	assign quot  = qt_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd30;
				num_q  <= {Ceiling, 15'd0};
				rem_q  <= '0;
				qt_q   <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[28:0], 1'b0};
				if (trial >= {1'b0, mag}) begin
					rem_q <= trial - {1'b0, mag};
					qt_q  <= {qt_q[28:0], 1'b1};
				end else begin
					rem_q <= trial;
					qt_q  <= {qt_q[28:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

[sim/tb_polyphonic_sample_mixer_limiter.sv]
// Testbench for polyphonic_sample_mixer_limiter: directed and random command streams
// checked against a cycle-free mixer/limiter predictor. Depends on psml_pkg and the RTL.
`timescale 1ns / 1ps
module tb_polyphonic_sample_mixer_limiter;
	import psml_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	polyphonic_sample_mixer_limiter i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// mixer model state
	logic        voice_on[NumVoices];
	logic [1:0]  voice_tbl[NumVoices];
	logic        voice_run[NumVoices];
	int          voice_pos[NumVoices];
	int          steal_ptr;
	int          lim_gain;
	logic [15:0] tbl_mem[MemDepth];
	int          vol_master, vol_duck, mute_on;
	int          tbl_len[3];

	logic [31:0] expected_results[$];
	int          errors;
	int          send_idle_pct;
	int          recv_stall_pct;
	longint      cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [15:0] mix_sample();
		longint acc, amp, outv, mag, desired;
		int t, len, mv, dv, gin;
		acc = 0;
		for (int v = 0; v < NumVoices; v++) begin
			if (voice_on[v]) begin
				if (!voice_run[v]) begin
					voice_run[v] = 1'b1;
					voice_pos[v] = 0;
				end
				t = voice_tbl[v];
				len = (t == 0) ? 0 : (tbl_len[t-1] > TableDepth ? TableDepth : tbl_len[t-1]);
				if (voice_pos[v] < len) begin
					acc += longint'($signed(tbl_mem[(t-1)*TableDepth + voice_pos[v]]));
					if (acc > 524287) acc = 524287;
					if (acc < -524288) acc = -524288;
					voice_pos[v] = (voice_pos[v] + 1) & 8191;
				end else begin
					voice_on[v] = 1'b0;
					voice_run[v] = 1'b0;
					voice_pos[v] = 0;
				end
			end
		end
		mv = vol_master > 32768 ? 32768 : vol_master;
		dv = vol_duck > 32768 ? 32768 : vol_duck;
		gin = mute_on ? 0 : ((mv * dv) >> 15);
		amp = (acc * gin) >>> 15;
		if (amp > 524287) amp = 524287;
		if (amp < -524288) amp = -524288;
		mag = amp < 0 ? -amp : amp;
		desired = 32768;
		if (mag > 31130) desired = (longint'(31130) * 32768) / mag;
		if (desired < lim_gain) lim_gain = int'(desired);
		else lim_gain += ((32768 - lim_gain) + 2047) >> 11;
		if (lim_gain > 32768) lim_gain = 32768;
		outv = (amp * lim_gain) >>> 15;
		if (outv > 32767) outv = 32767;
		if (outv < -32768) outv = -32768;
		return outv[15:0];
	endfunction

	function automatic logic [31:0] mix_predict(cmd_t cmd, logic [1:0] tt, logic [11:0] addr,
		logic [15:0] word);
		logic [15:0] smp;
		int          used, stolen, n;
		smp = '0;
		used = 0;
		stolen = 0;
		case (cmd)
			CMD_SAMPLE: smp = mix_sample();
			CMD_TRIGGER: begin
				used = -1;
				for (int v = NumVoices - 1; v >= 0; v--)
					if (!voice_on[v]) used = v;
				if (used < 0) begin
					used = steal_ptr;
					steal_ptr = (steal_ptr + 1) % NumVoices;
					stolen = 1;
				end
				voice_on[used] = 1'b1;
				voice_tbl[used] = tt;
				voice_run[used] = 1'b0;
				voice_pos[used] = 0;
			end
			CMD_LOAD: if (tt != 0) tbl_mem[(tt-1)*TableDepth + addr] = word;
			default: begin
				for (int v = 0; v < NumVoices; v++) begin
					voice_on[v] = 1'b0;
					voice_run[v] = 1'b0;
					voice_pos[v] = 0;
				end
				steal_ptr = 0;
			end
		endcase
		n = 0;
		for (int v = 0; v < NumVoices; v++) n += voice_on[v];
		return {7'b0, 4'(n), 1'(stolen), 4'(used), smp};
	endfunction

	task automatic send_request(cmd_t cmd, logic [1:0] tt, logic [11:0] addr, logic [15:0] word);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {2'b00, word, addr, tt};
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(mix_predict(cmd, tt, addr, word));
	endtask

	task automatic write_reg(reg_t idx, logic [15:0] val);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MASTER: vol_master = val;
			REG_DUCK:   vol_duck = val;
			REG_MUTED:  mute_on = val[0];
			REG_LEN_S:  tbl_len[0] = val[12:0];
			REG_LEN_N:  tbl_len[1] = val[12:0];
			default:    tbl_len[2] = val[12:0];
		endcase
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
				errors++;
			end else begin
				logic [31:0] e;
				e = expected_results.pop_front();
				if (e[15:0] !== m_axis_tdata[15:0]) begin
					$display("%0t: sample_out expected %h actual %h", $time, e[15:0],
						m_axis_tdata[15:0]);
					errors++;
				end
				if (e[19:16] !== m_axis_tdata[19:16]) begin
					$display("%0t: voice_used expected %0d actual %0d", $time, e[19:16],
						m_axis_tdata[19:16]);
					errors++;
				end
				if (e[20] !== m_axis_tdata[20]) begin
					$display("%0t: voice_stolen expected %b actual %b", $time, e[20],
						m_axis_tdata[20]);
					errors++;
				end
				if (e[24:21] !== m_axis_tdata[24:21]) begin
					$display("%0t: active_voices expected %0d actual %0d", $time, e[24:21],
						m_axis_tdata[24:21]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// strong table over its first 256 words, the others over their first 64
	task automatic test_fill_tables();
		send_request(CMD_LOAD, 2'd1, 12'd0, 16'h8000);
		send_request(CMD_LOAD, 2'd1, 12'd1, 16'h7fff);
		for (int a = 2; a < 256; a++)
			send_request(CMD_LOAD, 2'd1, 12'(a), 16'($urandom));
		for (int t = 2; t <= 3; t++)
			for (int a = 0; a < 64; a++)
				send_request(CMD_LOAD, 2'(t), 12'(a), 16'($urandom));
	endtask

	task automatic test_directed();
		write_reg(REG_LEN_S, 16'd16);
		write_reg(REG_LEN_N, 16'd64);
		write_reg(REG_LEN_SUB, 16'd0);
		send_request(CMD_TRIGGER, 2'd1, 12'd0, 16'd0);
		repeat (3) send_request(CMD_SAMPLE, 2'd0, 12'd0, 16'd0);
		send_request(CMD_TRIGGER, 2'd2, 12'd0, 16'd0);
		send_request(CMD_TRIGGER, 2'd0, 12'd0, 16'd0);
		send_request(CMD_TRIGGER, 2'd3, 12'd0, 16'd0);
		repeat (2) send_request(CMD_SAMPLE, 2'd0, 12'd0, 16'd0);
		send_request(CMD_LOAD, 2'd0, 12'hfff, 16'hffff);
		repeat (11) send_request(CMD_TRIGGER, 2'($urandom_range(1, 2)), 12'd0, 16'd0);
		repeat (4) send_request(CMD_SAMPLE, 2'd0, 12'd0, 16'd0);
		send_request(CMD_STOP, 2'd3, 12'hfff, 16'hffff);
		send_request(CMD_SAMPLE, 2'd0, 12'd0, 16'd0);
	endtask

	// length above the table depth, volumes above unity, two voices over many samples
	task automatic test_long_voice();
		write_reg(REG_LEN_S, 16'd8191);
		write_reg(REG_MASTER, 16'hffff);
		write_reg(REG_DUCK, 16'hffff);
		send_request(CMD_TRIGGER, 2'd1, 12'd0, 16'd0);
		send_request(CMD_TRIGGER, 2'd1, 12'd0, 16'd0);
		repeat (200) send_request(CMD_SAMPLE, 2'd0, 12'd0, 16'd0);
		send_request(CMD_STOP, 2'd0, 12'd0, 16'd0);
	endtask

	function automatic logic [15:0] pick_volume();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'hffff;
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	task automatic test_random(int idle, int stall, int count);
		int r;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		write_reg(REG_MASTER, pick_volume());
		write_reg(REG_DUCK, pick_volume());
		write_reg(REG_MUTED, 16'($urandom_range(3) == 0));
		write_reg(REG_LEN_S, 16'($urandom_range(256)));
		write_reg(REG_LEN_N, 16'($urandom_range(64)));
		write_reg(REG_LEN_SUB, 16'($urandom_range(64)));
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				send_request(CMD_SAMPLE, 2'($urandom), 12'($urandom), 16'($urandom));
			else if (r < 78)
				send_request(CMD_TRIGGER, 2'($urandom), 12'($urandom), 16'($urandom));
			else if (r < 95)
				send_request(CMD_LOAD, 2'($urandom), 12'($urandom), 16'($urandom));
			else
				send_request(CMD_STOP, 2'($urandom), 12'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = CMD_SAMPLE;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MASTER;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		vol_master = 32768;
		vol_duck = 32768;
		mute_on = 0;
		steal_ptr = 0;
		lim_gain = 32768;
		for (int i = 0; i < 3; i++) tbl_len[i] = 0;
		for (int v = 0; v < NumVoices; v++) begin
			voice_on[v] = 1'b0;
			voice_tbl[v] = '0;
			voice_run[v] = 1'b0;
			voice_pos[v] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fill_tables();
		test_directed();
		test_long_voice();
		test_random(0, 0, 125);
		test_random(55, 0, 125);
		test_random(0, 55, 125);
		test_random(7, 7, 125);
		test_random(55, 55, 125);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
